// ===== hdl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-associative tag store package
// Shared types and codes for the tag store controller and datapath.
// ----------------------------------------------------------------------------
package sact_pkg;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_FILL   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_LRU  = 2'd1,
		POL_LFU  = 2'd2,
		POL_NONE = 2'd3
	} policy_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// ===== hdl/sact_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/sact_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tag store controller
// Sequences capture, set read, execute and result hand-off.
// ----------------------------------------------------------------------------
module sact_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sact_pkg::cmd_t cmd
);

	sact_pkg::state_t state_q;

	assign in_stall      = (state_q != sact_pkg::ST_IDLE);
	assign out_valid     = (state_q == sact_pkg::ST_OUT);
	assign cmd.capture   = (state_q == sact_pkg::ST_IDLE) && in_valid;
	assign cmd.execute   = (state_q == sact_pkg::ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sact_pkg::ST_IDLE;
		end else begin
			case (state_q)
				sact_pkg::ST_IDLE: if (in_valid) state_q <= sact_pkg::ST_READ;
				sact_pkg::ST_READ: state_q <= sact_pkg::ST_EXEC;
				sact_pkg::ST_EXEC: state_q <= sact_pkg::ST_OUT;
				sact_pkg::ST_OUT:  if (!out_stall) state_q <= sact_pkg::ST_IDLE;
				default:           state_q <= sact_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/sact_dp.sv =====
// ----------------------------------------------------------------------------
// Tag store datapath
// Set memory, way compare, victim choice, metadata update and counters.
// ----------------------------------------------------------------------------
module sact_dp #(
	parameter int SET_COUNT     = 64,
	parameter int WAYS          = 4,
	parameter int LINE_OFS_BITS = 6,
	parameter int ADDR_BITS     = 32,
	parameter int TIME_BITS     = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sact_pkg::cmd_t cmd,
	input  logic           replace_policy_we,
	input  logic [1:0]     replace_policy_wdata,
	input  logic [1:0]     func,
	input  logic [31:0]    address,
	input  logic           wr_access,
	output logic           hit,
	output logic           writeback_valid,
	output logic [31:0]    writeback_addr,
	output logic [31:0]    hits_total,
	output logic [31:0]    misses_total
);

	localparam int IB    = $clog2(SET_COUNT) -
		(((1 << $clog2(SET_COUNT)) != SET_COUNT) ? 1 : 0);
	localparam int SETW  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int TAGW  = (ADDR_BITS - LINE_OFS_BITS - IB > 0) ?
		ADDR_BITS - LINE_OFS_BITS - IB : 1;
	localparam int LINEW = 2 + TAGW + 3 * TIME_BITS;
	localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int DEPTH = SET_COUNT;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef struct packed {
		logic                 valid;
		logic                 dirty;
		logic [TAGW-1:0]      tag;
		logic [TIME_BITS-1:0] last_use;
		logic [TIME_BITS-1:0] use_count;
		logic [TIME_BITS-1:0] fill_time;
	} line_t;

	logic [1:0]           policy_q;
	logic [1:0]           func_q;
	logic                 wr_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [31:0]          hits_q, misses_q;
	logic [DEPTH-1:0]     set_ok_q;
	logic [SETW-1:0]      set_idx;
	logic [TAGW-1:0]      tag_in;
	logic [ADDR_BITS-1:0] addr_ext;
	logic [WAYS*LINEW-1:0] rd_raw, wr_raw;
	line_t                lines [WAYS];
	line_t                upd [WAYS];
	logic [TIME_BITS-1:0] tick_nx;
	logic                 hit_c, inv_found;
	logic [WAYW-1:0]      hit_way, inv_way, vic_way, sel_way;
	logic                 wbv_c;
	logic [ADDR_BITS+IB:0] wba_full;

	always_comb begin
		addr_ext = '0;
		addr_ext = ADDR_BITS'(address);
	end
	assign set_idx = SETW'((addr_q >> LINE_OFS_BITS) & ADDR_BITS'(SET_COUNT - 1));
	assign tag_in  = TAGW'(addr_q >> (LINE_OFS_BITS + IB));

	sact_ram #(.WIDTH(WAYS*LINEW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.execute && (func_q == sact_pkg::FUNC_LOOKUP || func_q == sact_pkg::FUNC_FILL)),
		.waddr (set_idx),
		.wdata (wr_raw),
		.raddr (set_idx),
		.rdata (rd_raw)
	);

	assign tick_nx = (tick_q == TMAX) ? tick_q : tick_q + 1'b1;

	always_comb begin
		logic better;
		hit_c = 1'b0; hit_way = '0; inv_found = 1'b0; inv_way = '0; vic_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			lines[w] = set_ok_q[set_idx] ? line_t'(rd_raw[w*LINEW +: LINEW]) : line_t'('0);
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!hit_c && lines[w].valid && lines[w].tag == tag_in) begin
				hit_c = 1'b1; hit_way = WAYW'(w);
			end
			if (!inv_found && !lines[w].valid) begin
				inv_found = 1'b1; inv_way = WAYW'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			case (sact_pkg::policy_t'(policy_q))
				sact_pkg::POL_FIFO: better = lines[w].fill_time < lines[vic_way].fill_time;
				sact_pkg::POL_LRU:  better = lines[w].last_use < lines[vic_way].last_use;
				sact_pkg::POL_LFU:  better = lines[w].use_count < lines[vic_way].use_count ||
					(lines[w].use_count == lines[vic_way].use_count &&
					 lines[w].last_use < lines[vic_way].last_use);
				default:            better = 1'b0;
			endcase
			if (better) vic_way = WAYW'(w);
		end
		sel_way = inv_found ? inv_way : vic_way;
		wbv_c = !inv_found && lines[sel_way].dirty;
		wba_full = '0;
		wba_full = (ADDR_BITS+IB+1)'(lines[sel_way].tag) << (LINE_OFS_BITS + IB);
		wba_full = wba_full | ((ADDR_BITS+IB+1)'(set_idx) << LINE_OFS_BITS);
		for (int w = 0; w < WAYS; w++) begin
			upd[w] = lines[w];
			if (func_q == sact_pkg::FUNC_LOOKUP && hit_c && hit_way == WAYW'(w)) begin
				upd[w].last_use = tick_nx;
				if (lines[w].use_count != TMAX) upd[w].use_count = lines[w].use_count + 1'b1;
				if (wr_q) upd[w].dirty = 1'b1;
			end
			if (func_q == sact_pkg::FUNC_FILL && sel_way == WAYW'(w)) begin
				upd[w].valid = 1'b1; upd[w].dirty = wr_q; upd[w].tag = tag_in;
				upd[w].last_use = tick_nx; upd[w].fill_time = tick_nx;
				upd[w].use_count = TIME_BITS'(1);
			end
			wr_raw[w*LINEW +: LINEW] = upd[w];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func; wr_q <= wr_access; addr_q <= addr_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= sact_pkg::POL_LRU; tick_q <= '0; hits_q <= '0; misses_q <= '0;
			set_ok_q <= '0;
			hit <= 1'b0; writeback_valid <= 1'b0; writeback_addr <= '0;
		end else begin
			if (replace_policy_we) policy_q <= replace_policy_wdata;
			if (cmd.execute) begin
				hit <= 1'b0; writeback_valid <= 1'b0; writeback_addr <= '0;
				case (sact_pkg::func_t'(func_q))
					sact_pkg::FUNC_LOOKUP: begin
						tick_q <= tick_nx; set_ok_q[set_idx] <= 1'b1;
						hit <= hit_c;
						if (hit_c && hits_q != '1) hits_q <= hits_q + 1'b1;
						if (!hit_c && misses_q != '1) misses_q <= misses_q + 1'b1;
					end
					sact_pkg::FUNC_FILL: begin
						tick_q <= tick_nx; set_ok_q[set_idx] <= 1'b1;
						writeback_valid <= wbv_c;
						if (wbv_c) writeback_addr <= 32'(wba_full);
					end
					sact_pkg::FUNC_CLEAR: begin
						hits_q <= '0; misses_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign hits_total   = hits_q;
	assign misses_total = misses_q;

endmodule

// ===== hdl/set_assoc_cache_tag_store.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag store
// Lookup, fill and counter clear with FIFO, LRU or LFU replacement, or way 0 as victim under POL_NONE.
// ----------------------------------------------------------------------------
// A word is accepted only while the block is idle, and its result is offered
// in state OUT: in READ the whole set is read from one RAM row through the
// registered read port, in EXEC it is compared, updated and written back,
// and in OUT the result register holds the outcome. The next word is
// taken in the cycle after the result has been delivered, so a new word is
// never taken before the last one's result has gone out. The read-modify-write
// of the set row sets this sequence. A set never touched since reset reads as all invalid.
module set_assoc_cache_tag_store #(
	parameter int SET_COUNT     = 64,
	parameter int WAYS          = 4,
	parameter int LINE_OFS_BITS = 6,
	parameter int ADDR_BITS     = 32,
	parameter int TIME_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        replace_policy_we,
	input  logic [1:0]  replace_policy_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] address,
	input  logic        wr_access,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic        writeback_valid,
	output logic [31:0] writeback_addr,
	output logic [31:0] hits_total,
	output logic [31:0] misses_total
);

	sact_pkg::cmd_t cmd;

	sact_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
	);

	sact_dp #(
		.SET_COUNT(SET_COUNT), .WAYS(WAYS), .LINE_OFS_BITS(LINE_OFS_BITS),
		.ADDR_BITS(ADDR_BITS), .TIME_BITS(TIME_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.replace_policy_we(replace_policy_we), .replace_policy_wdata(replace_policy_wdata),
		.func(func), .address(address), .wr_access(wr_access),
		.hit(hit), .writeback_valid(writeback_valid), .writeback_addr(writeback_addr),
		.hits_total(hits_total), .misses_total(misses_total)
	);

endmodule

// ===== verif/set_assoc_cache_tag_store_tb.sv =====
// ----------------------------------------------------------------------------
// Tag store testbench
// Drives lookups, fills, counter clears and no-op words through the valid/stall word
// channels under every replacement policy, predicts each result word from a
// behavioral copy of the sets and counters, and checks it field by field.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS  = 64;
	localparam int NWAYS = 4;
	localparam int OFFB  = 6;
	localparam int IDXB  = 6;

	typedef struct {
		sact_pkg::func_t op;
		logic [31:0]     addr;
		logic            wr;
	} access_t;

	typedef struct {
		logic        hit;
		logic        wb_valid;
		logic [31:0] wb_addr;
		logic [31:0] hits;
		logic [31:0] misses;
	} outcome_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        replace_policy_we = 0;
	logic [1:0]  replace_policy_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [31:0] address = '0;
	logic        wr_access = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        hit;
	logic        writeback_valid;
	logic [31:0] writeback_addr;
	logic [31:0] hits_total;
	logic [31:0] misses_total;

	set_assoc_cache_tag_store dut (.*);

	always #5 clk = ~clk;

	// Predictor state.
	sact_pkg::policy_t cur_policy = sact_pkg::POL_LRU;
	logic        m_valid[SETS*NWAYS];
	logic        m_dirty[SETS*NWAYS];
	logic [19:0] m_tag[SETS*NWAYS];
	logic [31:0] m_last[SETS*NWAYS];
	logic [31:0] m_count[SETS*NWAYS];
	logic [31:0] m_filled[SETS*NWAYS];
	logic [31:0] m_ticks = 0;
	logic [31:0] m_hits = 0;
	logic [31:0] m_misses = 0;

	access_t  pending_words[$];
	outcome_t expected_results[$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       hit_count_seen = 0;
	int       writebacks_seen = 0;
	bit       gen_done = 0;
	bit       long_hold = 0;
	bit       driving_enabled = 1;
	bit       in_taken = 0;

	initial begin
		for (int i = 0; i < SETS*NWAYS; i++) begin
			m_valid[i] = 0;
			m_dirty[i] = 0;
		end
	end

	function automatic int choose_victim(int base);
		int best;
		bit better;
		best = 0;
		for (int w = 1; w < NWAYS; w++) begin
			case (cur_policy)
				sact_pkg::POL_FIFO: better = m_filled[base+w] < m_filled[base+best];
				sact_pkg::POL_LRU:  better = m_last[base+w] < m_last[base+best];
				sact_pkg::POL_LFU:  better = m_count[base+w] < m_count[base+best] ||
					(m_count[base+w] == m_count[base+best] &&
					 m_last[base+w] < m_last[base+best]);
				default:  better = 0;
			endcase
			if (better)
				best = w;
		end
		return best;
	endfunction

	function automatic outcome_t predict_access(access_t a);
		outcome_t r;
		int base;
		int l;
		logic [5:0] set_idx;
		logic [19:0] tg;
		r = '{default: '0};
		set_idx = a.addr[OFFB +: IDXB];
		tg = a.addr[31 -: 20];
		base = set_idx * NWAYS;
		if (a.op == sact_pkg::FUNC_LOOKUP) begin
			if (m_ticks != '1)
				m_ticks++;
			for (int w = 0; w < NWAYS; w++) begin
				if (!r.hit && m_valid[base+w] && m_tag[base+w] == tg) begin
					r.hit = 1;
					m_last[base+w] = m_ticks;
					if (m_count[base+w] != '1)
						m_count[base+w]++;
					if (a.wr)
						m_dirty[base+w] = 1;
				end
			end
			if (r.hit) begin
				if (m_hits != '1)
					m_hits++;
			end else if (m_misses != '1) begin
				m_misses++;
			end
		end else if (a.op == sact_pkg::FUNC_FILL) begin
			if (m_ticks != '1)
				m_ticks++;
			l = -1;
			for (int w = NWAYS-1; w >= 0; w--)
				if (!m_valid[base+w])
					l = base + w;
			if (l < 0) begin
				l = base + choose_victim(base);
				if (m_dirty[l]) begin
					r.wb_valid = 1;
					r.wb_addr = {m_tag[l], set_idx, 6'b0};
				end
			end
			m_tag[l] = tg;
			m_valid[l] = 1;
			m_dirty[l] = a.wr;
			m_last[l] = m_ticks;
			m_count[l] = 1;
			m_filled[l] = m_ticks;
		end else if (a.op == sact_pkg::FUNC_CLEAR) begin
			m_hits = 0;
			m_misses = 0;
		end
		r.hits = m_hits;
		r.misses = m_misses;
		return r;
	endfunction

	// Input acceptance: the word is taken at this edge.
	always @(posedge clk) begin
		in_taken = 0;
		if (arst_n && in_valid && !in_stall) begin
			in_taken = 1;
			void'(pending_words.pop_front());
			expected_results.push_back(predict_access(
				'{sact_pkg::func_t'(func), address, wr_access}));
		end
	end

	// Driver: bursts with random gaps.
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (driving_enabled && pending_words.size() > 0) begin
				in_valid <= 1;
				func <= pending_words[0].op;
				address <= pending_words[0].addr;
				wr_access <= pending_words[0].wr;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					if ($urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver stall pattern.
	int stall_mode = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode = $urandom_range(0, 2);
		if (long_hold)
			out_stall <= 1;
		else case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// Monitor.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at %0t", $realtime);
			end else begin
				e = expected_results.pop_front();
				if (hit) hit_count_seen++;
				if (writeback_valid) writebacks_seen++;
				if (hit !== e.hit || writeback_valid !== e.wb_valid ||
				    writeback_addr !== e.wb_addr || hits_total !== e.hits ||
				    misses_total !== e.misses) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp %0b %0b %h %0d %0d got %0b %0b %h %0d %0d",
							$realtime, e.hit, e.wb_valid, e.wb_addr, e.hits, e.misses,
							hit, writeback_valid, writeback_addr, hits_total,
							misses_total);
				end
			end
		end
	end

	function automatic logic [31:0] make_addr(int set_idx, int tg);
		return {tg[19:0], set_idx[5:0], 6'($urandom)};
	endfunction

	task automatic queue_word(sact_pkg::func_t op, logic [31:0] a, logic w);
		pending_words.push_back('{op, a, w});
	endtask

	task automatic drain_and_set(sact_pkg::policy_t p);
		while (pending_words.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		replace_policy_we <= 1;
		replace_policy_wdata <= p;
		cur_policy = p;
		@(negedge clk);
		replace_policy_we <= 0;
	endtask

	// Random phase: mostly fill/lookup words over eight hot sets, mixed with clears, no-ops and random-address words.
	task automatic random_phase(int n);
		int s;
		int t;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, 7);
			t = $urandom_range(0, 7);
			if (r < 3)
				queue_word(sact_pkg::FUNC_CLEAR, $urandom, $urandom_range(0, 1));
			else if (r < 5)
				queue_word(sact_pkg::FUNC_NONE, $urandom, $urandom_range(0, 1));
			else if (r < 10)
				queue_word(sact_pkg::func_t'($urandom_range(0, 1)), $urandom,
					$urandom_range(0, 1));
			else if (r < 40)
				queue_word(sact_pkg::FUNC_FILL, make_addr(s, t), $urandom_range(0, 1));
			else
				queue_word(sact_pkg::FUNC_LOOKUP, make_addr(s, t), $urandom_range(0, 1));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// Directed: extremes, every operation, duplicates, dirty eviction.
		queue_word(sact_pkg::FUNC_LOOKUP, 32'h0000_0000, 0);
		queue_word(sact_pkg::FUNC_FILL, 32'hFFFF_FFFF, 1);
		queue_word(sact_pkg::FUNC_LOOKUP, 32'hFFFF_FFC0, 0);
		queue_word(sact_pkg::FUNC_FILL, 32'h0000_0000, 0);
		queue_word(sact_pkg::FUNC_FILL, 32'h0000_0000, 1);
		queue_word(sact_pkg::FUNC_LOOKUP, 32'h0000_003F, 1);
		queue_word(sact_pkg::FUNC_NONE, 32'h1234_5678, 1);
		for (int i = 0; i < 6; i++)
			queue_word(sact_pkg::FUNC_FILL, make_addr(63, i + 100), i[0]);
		queue_word(sact_pkg::FUNC_LOOKUP, make_addr(63, 103), 1);
		queue_word(sact_pkg::FUNC_CLEAR, 32'hAAAA_5555, 0);
		queue_word(sact_pkg::FUNC_LOOKUP, 32'h5555_AAAA, 0);
		drain_and_set(sact_pkg::POL_FIFO);
		random_phase(350);
		drain_and_set(sact_pkg::POL_LFU);
		random_phase(350);
		drain_and_set(sact_pkg::POL_NONE);
		random_phase(200);
		drain_and_set(sact_pkg::POL_LRU);
		random_phase(250);
		// Long receiver hold while the sender keeps offering words.
		while (pending_words.size() > 150) @(posedge clk);
		long_hold = 1;
		repeat (300) @(posedge clk);
		long_hold = 0;
		drain_and_set(sact_pkg::POL_FIFO);
		random_phase(200);
		drain_and_set(sact_pkg::POL_LFU);
		random_phase(200);
		gen_done = 1;
	end

	initial begin
		wait (gen_done);
		while (pending_words.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d result words: %0d hits, %0d write-backs, all policies.",
			results_seen, hit_count_seen, writebacks_seen);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

endmodule
